@@ rtl/core/hu_moment_invariants_macros.svh @@
// Assertion macros for the Hu moment invariant RTL.
// Files that check their own logic include this header; it depends on nothing else.
`ifndef HU_MOMENT_INVARIANTS_MACROS_SVH
`define HU_MOMENT_INVARIANTS_MACROS_SVH
`ifndef SYNTHESIS
// Checked in clk, disabled while rst is high.
`define HMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked in clk at every edge, reset included.
`define HMI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMI_ASSERT(lbl, prop, msg)
`define HMI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/hmi_pkg.sv @@
// Shared widths, the multiplier stage control type and the Q56 rounding function
// for the Hu moment invariant pipeline. No dependencies.
`timescale 1ns / 1ps

package hmi_pkg;

  localparam int IN_W     = 32;           // Q1.30 moment
  localparam int IN_FRAC  = 30;
  localparam int OUT_W    = 64;           // Q7.56 invariant
  localparam int OUT_FRAC = 56;

  localparam int A_W    = IN_W + 3;       // nu30 - 3*nu12 and 3*nu21 - nu03
  localparam int C_W    = IN_W + 1;       // sums and differences of two moments
  localparam int SQ_W   = 2 * C_W;        // products of two C_W values
  localparam int MUL_W  = A_W + C_W;      // operand width of the wide multipliers
  localparam int H_W    = 2 * A_W;        // second order invariants, Q60
  localparam int PROD_W = 2 * MUL_W;      // wide multiplier product
  localparam int RND_W  = PROD_W + 1;     // headroom for the rounding add

  // Right shifts that bring each exact value to Q56.
  localparam logic [7:0] SH_Q60  = 8'd4;
  localparam logic [7:0] SH_Q90  = 8'd34;
  localparam logic [7:0] SH_Q120 = 8'd64;

  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Load enables of the two register stages inside a wide multiplier.
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

  // Round to nearest with ties toward plus infinity, then saturate to 64 bits.
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [RND_W-1:0] x,
                                                        input logic [7:0] sh);
    logic signed [RND_W-1:0] half;
    logic signed [RND_W-1:0] r;
    logic                    fits;
    half = RND_W'(1) << (sh - 8'd1);
    r    = (x + half) >>> sh;
    fits = (&r[RND_W-1:OUT_W-1]) || !(|r[RND_W-1:OUT_W-1]);
    if (fits) begin
      round_sat = r[OUT_W-1:0];
    end else begin
      round_sat = r[RND_W-1] ? SAT_MIN : SAT_MAX;
    end
  endfunction

endpackage

@@ rtl/core/hu_moment_invariants.sv @@
// Hu moment invariants: seven Q1.30 normalized moments in, seven saturating Q7.56 invariants out.
// Seven register stages; one item is accepted per cycle while the output is taken. Each stage
// holds its item when the stage after it cannot load, so bubbles close up under a stall.
// Depends on hmi_pkg, hmi_mul and the macro header. Synchronous active-high rst empties every
// stage; data registers are not reset.
`timescale 1ns / 1ps
`include "hu_moment_invariants_macros.svh"

module hu_moment_invariants
  import hmi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  mom_20,
  input  logic signed [IN_W-1:0]  mom_11,
  input  logic signed [IN_W-1:0]  mom_02,
  input  logic signed [IN_W-1:0]  mom_30,
  input  logic signed [IN_W-1:0]  mom_21,
  input  logic signed [IN_W-1:0]  mom_12,
  input  logic signed [IN_W-1:0]  mom_03,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] hu_one,
  output logic signed [OUT_W-1:0] hu_two,
  output logic signed [OUT_W-1:0] hu_three,
  output logic signed [OUT_W-1:0] hu_four,
  output logic signed [OUT_W-1:0] hu_five,
  output logic signed [OUT_W-1:0] hu_six,
  output logic signed [OUT_W-1:0] hu_seven
);

  // Stage map:
  //   1  sums and differences of the moments (a, b, c, d, e, h1)
  //   2  the products of pairs of first-level terms that the invariants need, and nu11^2
  //   3  p = c^2 - 3d^2, q = 3c^2 - d^2, c^2 - d^2 and the second order invariants
  //   4  partial products of the wide multipliers
  //   5  wide products assembled
  //   6  third order invariants summed exactly
  //   7  rounding to Q56 and saturation, the output register
  localparam int NSTG = 7;

  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NSTG] = !vld[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: first-level terms, all exact in Q30.
  logic signed [A_W-1:0]  s1_a, s1_b;
  logic signed [C_W-1:0]  s1_c, s1_d, s1_e, s1_h1;
  logic signed [IN_W-1:0] s1_n11;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a   <= A_W'(mom_30) - (A_W'(mom_12) <<< 1) - A_W'(mom_12);
      s1_b   <= (A_W'(mom_21) <<< 1) + A_W'(mom_21) - A_W'(mom_03);
      s1_c   <= C_W'(mom_30) + C_W'(mom_12);
      s1_d   <= C_W'(mom_21) + C_W'(mom_03);
      s1_e   <= C_W'(mom_20) - C_W'(mom_02);
      s1_h1  <= C_W'(mom_20) + C_W'(mom_02);
      s1_n11 <= mom_11;
    end
  end

  // Stage 2: one narrow multiplier per product, Q60 results.
  logic signed [SQ_W-1:0]   s2_c2, s2_d2, s2_cd, s2_e2;
  logic signed [MUL_W-1:0]  s2_ac, s2_bd, s2_bc, s2_ad;
  logic signed [H_W-1:0]    s2_a2, s2_b2;
  logic signed [2*IN_W-1:0] s2_n2;
  logic signed [C_W-1:0]    s2_e, s2_h1;
  logic signed [IN_W-1:0]   s2_n11;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_c2  <= SQ_W'(s1_c) * SQ_W'(s1_c);
      s2_d2  <= SQ_W'(s1_d) * SQ_W'(s1_d);
      s2_cd  <= SQ_W'(s1_c) * SQ_W'(s1_d);
      s2_e2  <= SQ_W'(s1_e) * SQ_W'(s1_e);
      s2_ac  <= MUL_W'(s1_a) * MUL_W'(s1_c);
      s2_bd  <= MUL_W'(s1_b) * MUL_W'(s1_d);
      s2_bc  <= MUL_W'(s1_b) * MUL_W'(s1_c);
      s2_ad  <= MUL_W'(s1_a) * MUL_W'(s1_d);
      s2_a2  <= H_W'(s1_a) * H_W'(s1_a);
      s2_b2  <= H_W'(s1_b) * H_W'(s1_b);
      s2_n2  <= (2*IN_W)'(s1_n11) * (2*IN_W)'(s1_n11);
      s2_e   <= s1_e;
      s2_h1  <= s1_h1;
      s2_n11 <= s1_n11;
    end
  end

  // Stage 3: the cubic factors and the second order invariants.
  logic signed [MUL_W-1:0] s3_p, s3_q, s3_s;
  logic signed [MUL_W-1:0] s3_ac, s3_bd, s3_bc, s3_ad;
  logic signed [SQ_W-1:0]  s3_cd;
  logic signed [H_W-1:0]   s3_h2, s3_h3, s3_h4;
  logic signed [C_W-1:0]   s3_e, s3_h1;
  logic signed [IN_W-1:0]  s3_n11;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_p   <= MUL_W'(s2_c2) - (MUL_W'(s2_d2) <<< 1) - MUL_W'(s2_d2);
      s3_q   <= (MUL_W'(s2_c2) <<< 1) + MUL_W'(s2_c2) - MUL_W'(s2_d2);
      s3_s   <= MUL_W'(s2_c2) - MUL_W'(s2_d2);
      s3_h2  <= H_W'(s2_e2) + (H_W'(s2_n2) <<< 2);
      s3_h3  <= s2_a2 + s2_b2;
      s3_h4  <= H_W'(s2_c2) + H_W'(s2_d2);
      s3_ac  <= s2_ac;
      s3_bd  <= s2_bd;
      s3_bc  <= s2_bc;
      s3_ad  <= s2_ad;
      s3_cd  <= s2_cd;
      s3_e   <= s2_e;
      s3_h1  <= s2_h1;
      s3_n11 <= s2_n11;
    end
  end

  // Stages 4 and 5: the wide products. h5 and h7 need Q120, h6 needs Q90.
  mul_en_t                  men;
  logic signed [PROD_W-1:0] p_acp, p_bdq, p_bcp, p_adq, p_es, p_cdn;

  assign men.pp  = en[4];
  assign men.sum = en[5];

  hmi_mul u_mul_acp (.clk(clk), .en(men), .op_a(s3_ac), .op_b(s3_p), .prod(p_acp));
  hmi_mul u_mul_bdq (.clk(clk), .en(men), .op_a(s3_bd), .op_b(s3_q), .prod(p_bdq));
  hmi_mul u_mul_bcp (.clk(clk), .en(men), .op_a(s3_bc), .op_b(s3_p), .prod(p_bcp));
  hmi_mul u_mul_adq (.clk(clk), .en(men), .op_a(s3_ad), .op_b(s3_q), .prod(p_adq));
  hmi_mul u_mul_es  (.clk(clk), .en(men), .op_a(MUL_W'(s3_e)), .op_b(s3_s), .prod(p_es));
  hmi_mul u_mul_cdn (.clk(clk), .en(men), .op_a(MUL_W'(s3_cd)), .op_b(MUL_W'(s3_n11)),
                     .prod(p_cdn));

  // The first four invariants ride alongside the multipliers.
  logic signed [C_W-1:0] s4_h1, s5_h1, s6_h1;
  logic signed [H_W-1:0] s4_h2, s4_h3, s4_h4;
  logic signed [H_W-1:0] s5_h2, s5_h3, s5_h4;
  logic signed [H_W-1:0] s6_h2, s6_h3, s6_h4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_h1 <= s3_h1;
      s4_h2 <= s3_h2;
      s4_h3 <= s3_h3;
      s4_h4 <= s3_h4;
    end
    if (en[5]) begin
      s5_h1 <= s4_h1;
      s5_h2 <= s4_h2;
      s5_h3 <= s4_h3;
      s5_h4 <= s4_h4;
    end
  end

  // Stage 6: exact sums of the wide products. None of them can overflow PROD_W.
  logic signed [PROD_W-1:0] s6_h5, s6_h6, s6_h7;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_h5 <= p_acp + p_bdq;
      s6_h6 <= p_es + (p_cdn <<< 2);
      s6_h7 <= p_bcp - p_adq;
      s6_h1 <= s5_h1;
      s6_h2 <= s5_h2;
      s6_h3 <= s5_h3;
      s6_h4 <= s5_h4;
    end
  end

  // Stage 7: one rounding to Q56 for each of h2 to h7. h1 only gains fraction bits and always fits.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      hu_one   <= OUT_W'(s6_h1) <<< (OUT_FRAC - IN_FRAC);
      hu_two   <= round_sat(RND_W'(s6_h2), SH_Q60);
      hu_three <= round_sat(RND_W'(s6_h3), SH_Q60);
      hu_four  <= round_sat(RND_W'(s6_h4), SH_Q60);
      hu_five  <= round_sat(RND_W'(s6_h5), SH_Q120);
      hu_six   <= round_sat(RND_W'(s6_h6), SH_Q90);
      hu_seven <= round_sat(RND_W'(s6_h7), SH_Q120);
    end
  end

  // An accepted item must occupy the first stage on the next cycle.
  `HMI_ASSERT(a_accept_enters, in_valid && in_ready |=> vld[1], "accepted item lost at entry")
  // The full fourth stage keeps its item while it cannot move on.
  `HMI_ASSERT(a_mid_holds, vld[4] && !en[5] |=> vld[4], "item dropped inside the multipliers")
  // Sums of squares never come out negative, before or after saturation.
  `HMI_ASSERT(a_two_nonneg, out_valid |-> !hu_two[OUT_W-1], "second invariant negative")
  `HMI_ASSERT(a_sq_nonneg, out_valid |-> !hu_three[OUT_W-1] && !hu_four[OUT_W-1],
              "third or fourth invariant negative")
  // Reset leaves the pipeline empty.
  `HMI_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !vld[1], "pipeline not empty after reset")

endmodule

@@ rtl/core/hmi_mul.sv @@
// Two-stage signed multiplier for MUL_W-bit operands, built from four half-width products.
// Depends on hmi_pkg for widths and the stage enable type.
`timescale 1ns / 1ps

module hmi_mul
  import hmi_pkg::*;
(
  input  logic                     clk,
  input  mul_en_t                  en,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  localparam int LO_W = MUL_W / 2;
  localparam int HI_W = MUL_W - LO_W;
  localparam int LL_W = 2 * LO_W + 2;
  localparam int LH_W = LO_W + HI_W + 1;
  localparam int HH_W = 2 * HI_W;

  logic signed [LO_W:0]   a_lo, b_lo;
  logic signed [HI_W-1:0] a_hi, b_hi;

  logic signed [LL_W-1:0] pp_ll;
  logic signed [LH_W-1:0] pp_lh, pp_hl;
  logic signed [HH_W-1:0] pp_hh;

  // Low halves are unsigned; the zero on top keeps them positive in signed products.
  assign a_lo = {1'b0, op_a[LO_W-1:0]};
  assign b_lo = {1'b0, op_b[LO_W-1:0]};
  assign a_hi = op_a[MUL_W-1:LO_W];
  assign b_hi = op_b[MUL_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_ll <= LL_W'(a_lo) * LL_W'(b_lo);
      pp_lh <= LH_W'(a_lo) * LH_W'(b_hi);
      pp_hl <= LH_W'(a_hi) * LH_W'(b_lo);
      pp_hh <= HH_W'(a_hi) * HH_W'(b_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      prod <= PROD_W'(pp_ll)
            + (PROD_W'(pp_lh) <<< LO_W)
            + (PROD_W'(pp_hl) <<< LO_W)
            + (PROD_W'(pp_hh) <<< (2 * LO_W));
    end
  end

endmodule

@@ bench/tb_hu_moment_invariants.sv @@
// Self-checking bench for hu_moment_invariants: directed table, then random moment sets.
// Depends on hmi_pkg and the hu_moment_invariants RTL; reads no files.
`timescale 1ns / 1ps

module tb_hu_moment_invariants
  import hmi_pkg::*;
();

  // Run length and timing knobs.
  localparam int N_RANDOM    = 1000;
  localparam int PAUSE_AT    = 500;     // random item before which the sender drains the pipe
  localparam int LONG_HOLD   = 120;     // receiver hold-off in cycles, fills the pipeline
  localparam int HOLD_PHASE  = 40;      // receiver phase at which the long hold-off happens
  localparam int DRAIN_WAIT  = 20;      // extra cycles after the last result, to catch any extra output
  localparam int CYCLE_LIMIT = 600000;

  // Handy Q1.30 input values.
  localparam logic signed [IN_W-1:0] M_MIN     = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] M_MAX     = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] Q_ONE     = 32'sh4000_0000;
  localparam logic signed [IN_W-1:0] Q_NEG_ONE = 32'shC000_0000;

  // Handy Q7.56 output values.
  localparam logic signed [OUT_W-1:0] HU_ONE_Q56 = 64'sh0100_0000_0000_0000;

  // One item: the seven normalized moments, in the order of the ports.
  typedef struct packed {
    logic signed [IN_W-1:0] n20;
    logic signed [IN_W-1:0] n11;
    logic signed [IN_W-1:0] n02;
    logic signed [IN_W-1:0] n30;
    logic signed [IN_W-1:0] n21;
    logic signed [IN_W-1:0] n12;
    logic signed [IN_W-1:0] n03;
  } moment_set_t;

  // One result: the seven invariants, h1 in the top bits.
  typedef struct packed {
    logic signed [OUT_W-1:0] h1;
    logic signed [OUT_W-1:0] h2;
    logic signed [OUT_W-1:0] h3;
    logic signed [OUT_W-1:0] h4;
    logic signed [OUT_W-1:0] h5;
    logic signed [OUT_W-1:0] h6;
    logic signed [OUT_W-1:0] h7;
  } hu_set_t;

  // A row of the directed table. When has_known is set the result is typed in by hand.
  typedef struct {
    moment_set_t moments;
    bit          has_known;
    hu_set_t     known;
  } dir_row_t;

  // Exact arithmetic is done at 256 bits; degree four products of these inputs need
  // well under 160 bits, so nothing wraps.
  typedef logic signed [255:0] wide_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  moment_set_t in_set = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hu_set_t     out_set;

  // Side information that travels with the item on offer.
  logic        row_has_known = 1'b0;
  hu_set_t     row_known = '0;

  hu_set_t     pending_hu[$];
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hu_moment_invariants u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mom_20   (in_set.n20),
    .mom_11   (in_set.n11),
    .mom_02   (in_set.n02),
    .mom_30   (in_set.n30),
    .mom_21   (in_set.n21),
    .mom_12   (in_set.n12),
    .mom_03   (in_set.n03),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hu_one   (out_set.h1),
    .hu_two   (out_set.h2),
    .hu_three (out_set.h3),
    .hu_four  (out_set.h4),
    .hu_five  (out_set.h5),
    .hu_six   (out_set.h6),
    .hu_seven (out_set.h7)
  );

  // Brings an exact value with frac fraction bits to Q56. Extra fraction bits are rounded
  // to nearest with a tie going toward plus infinity; anything outside the signed 64-bit
  // range clips to the nearer limit.
  function automatic logic signed [OUT_W-1:0] to_q56(input wide_t x, input int unsigned frac);
    wide_t r;
    if (frac > OUT_FRAC) begin
      r = (x + (wide_t'(1) <<< (frac - OUT_FRAC - 1))) >>> (frac - OUT_FRAC);
    end else begin
      r = x <<< (OUT_FRAC - frac);
    end
    if (r > wide_t'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (r < wide_t'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return r[OUT_W-1:0];
  endfunction

  // The seven Hu invariants of one moment set, worked out exactly and rounded once each.
  function automatic hu_set_t hu_invariants_of(input moment_set_t m);
    wide_t n20, n11, n02, n30, n21, n12, n03;
    wide_t a, b, c, d, e, c2, d2, p, q;
    hu_set_t h;
    n20 = $signed(m.n20);
    n11 = $signed(m.n11);
    n02 = $signed(m.n02);
    n30 = $signed(m.n30);
    n21 = $signed(m.n21);
    n12 = $signed(m.n12);
    n03 = $signed(m.n03);
    a  = n30 - 3 * n12;
    b  = 3 * n21 - n03;
    c  = n30 + n12;
    d  = n21 + n03;
    e  = n20 - n02;
    c2 = c * c;
    d2 = d * d;
    p  = c2 - 3 * d2;
    q  = 3 * c2 - d2;
    // Degree sets the binary point: Q30 for h1, Q60 for the squares, Q90 and Q120 above.
    h.h1 = to_q56(n20 + n02, IN_FRAC);
    h.h2 = to_q56(e * e + 4 * n11 * n11, 2 * IN_FRAC);
    h.h3 = to_q56(a * a + b * b, 2 * IN_FRAC);
    h.h4 = to_q56(c2 + d2, 2 * IN_FRAC);
    h.h5 = to_q56(a * c * p + b * d * q, 4 * IN_FRAC);
    h.h6 = to_q56(e * (c2 - d2) + 4 * n11 * c * d, 3 * IN_FRAC);
    h.h7 = to_q56(b * c * p - a * d * q, 4 * IN_FRAC);
    return h;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Random moment with a mix of shapes: any bit pattern, values near zero so that the
  // rounding bits matter, values of magnitude below one as real moments have, and the
  // extremes of the Q1.30 range.
  function automatic logic signed [IN_W-1:0] pick_moment();
    int unsigned roll;
    logic        s;
    roll = $urandom_range(0, 99);
    s    = 1'($urandom);
    if (roll < 30) begin
      return $urandom;
    end else if (roll < 50) begin
      return {{(IN_W-8){s}}, 8'($urandom)};
    end else if (roll < 85) begin
      return {{2{s}}, 30'($urandom)};
    end
    case ($urandom_range(0, 6))
      0: return M_MIN;
      1: return M_MAX;
      2: return '0;
      3: return -1;
      4: return 1;
      5: return Q_ONE;
      default: return Q_NEG_ONE;
    endcase
  endfunction

  // Idle stretch length, shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input moment_set_t m, input bit has_known, input hu_set_t known);
    dir_row_t row;
    row.moments   = m;
    row.has_known = has_known;
    row.known     = known;
    dir_rows.push_back(row);
  endtask

  // Offers one item, after gap idle cycles, and returns at the edge where it is taken.
  // The caller is always sitting on a rising edge, so each call drives every signal once
  // per edge at most.
  task automatic offer_moments(input moment_set_t m, input bit has_known, input hu_set_t known,
                               input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_set        <= m;
    row_has_known <= has_known;
    row_known     <= known;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Checker. Everything is sampled on the rising edge, where the values seen are the ones
  // the RTL saw, since all bench drives are nonblocking. An accepted item queues its result
  // (typed in or predicted); each accepted result is compared with the oldest in the queue.
  always @(posedge clk) begin
    hu_set_t want;
    string   field_names[7];
    field_names = '{"hu_one", "hu_two", "hu_three", "hu_four", "hu_five", "hu_six", "hu_seven"};
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_hu.push_back(row_has_known ? row_known : hu_invariants_of(in_set));
      end
      if (out_valid && out_ready) begin
        if (pending_hu.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with none outstanding", results_seen));
        end else begin
          want = pending_hu.pop_front();
          for (int k = 0; k < 7; k++) begin
            if (out_set[(6-k)*OUT_W +: OUT_W] !== want[(6-k)*OUT_W +: OUT_W]) begin
              note_mismatch($sformatf("result %0d %s: got %h, wanted %h", results_seen,
                                      field_names[k], out_set[(6-k)*OUT_W +: OUT_W],
                                      want[(6-k)*OUT_W +: OUT_W]));
            end
          end
        end
        results_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: alternates runs of ready with idle stretches. Once, it holds off for a long
  // stretch while the sender keeps offering, so the pipeline fills and in_ready drops.
  initial begin
    int phase;
    int hold;
    int run;
    phase = 0;
    while (rst) @(posedge clk);
    forever begin
      phase++;
      hold = (phase == HOLD_PHASE) ? LONG_HOLD : pick_gap();
      repeat (hold) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Sender: reset, the directed table, then random items.
  initial begin
    moment_set_t m;
    int          gap;

    // Zero in, zero out.
    add_row('0, 1'b1, '0);
    // nu20 = 1.0 alone: h1 = 1.0 and h2 = e^2 = 1.0, the rest vanish.
    add_row('{n20: Q_ONE, default: '0}, 1'b1,
            '{h1: HU_ONE_Q56, h2: HU_ONE_Q56, default: '0});
    // All moments at -2.0: h5 = 1024 clips high; h6 lands exactly on -128, the lowest
    // value that still fits; h7 cancels to zero.
    add_row('{default: M_MIN}, 1'b1,
            '{h1: 64'shFC00_0000_0000_0000, h2: 64'sh1000_0000_0000_0000,
              h3: 64'sh2000_0000_0000_0000, h4: 64'sh2000_0000_0000_0000,
              h5: SAT_MAX, h6: 64'sh8000_0000_0000_0000, h7: '0});
    // nu11 = -2.0 alone: only h2 = 4 * nu11^2 = 16 survives.
    add_row('{n11: M_MIN, default: '0}, 1'b1, '{h2: 64'sh1000_0000_0000_0000, default: '0});
    // Exact rounding tie in h2: 2^2 + 4 * 1^2 = 8 at Q60 is half an LSB at Q56, rounds up.
    add_row('{n20: 32'sd2, n11: 32'sd1, default: '0}, 1'b1,
            '{h1: 64'sh0000_0000_0800_0000, h2: 64'sh1, default: '0});
    add_row('{default: M_MAX}, 1'b0, '0);
    // Each moment alone at an end of the range; the third order moments at both ends.
    add_row('{n20: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n02: M_MIN, default: '0}, 1'b0, '0);
    add_row('{n11: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n30: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n30: M_MIN, default: '0}, 1'b0, '0);
    add_row('{n21: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n21: M_MIN, default: '0}, 1'b0, '0);
    add_row('{n12: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n12: M_MIN, default: '0}, 1'b0, '0);
    add_row('{n03: M_MAX, default: '0}, 1'b0, '0);
    add_row('{n03: M_MIN, default: '0}, 1'b0, '0);
    // Smallest steps, where rounding decides everything.
    add_row('{default: 32'sd1}, 1'b0, '0);
    add_row('{default: -32'sd1}, 1'b0, '0);
    // Alternating bit patterns and mixed extremes.
    add_row('{n20: 32'sh5555_5555, n11: 32'shAAAA_AAAA, n02: 32'sh5555_5555,
              n30: 32'shAAAA_AAAA, n21: 32'sh5555_5555, n12: 32'shAAAA_AAAA,
              n03: 32'sh5555_5555}, 1'b0, '0);
    add_row('{n20: M_MAX, n11: M_MIN, n02: M_MIN, n30: M_MAX, n21: M_MIN, n12: M_MAX,
              n03: M_MIN}, 1'b0, '0);
    // Third order terms that cancel in c and in d, then a mix of unit and extreme moments.
    add_row('{n30: Q_ONE, n12: Q_NEG_ONE, n21: Q_NEG_ONE, n03: Q_ONE, default: '0}, 1'b0, '0);
    add_row('{n20: Q_ONE, n11: Q_NEG_ONE, n02: Q_NEG_ONE, n30: M_MIN, n21: M_MAX,
              n12: M_MIN, n03: M_MAX}, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_moments(dir_rows[i].moments, dir_rows[i].has_known, dir_rows[i].known, pick_gap());
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      m.n20 = pick_moment();
      m.n11 = pick_moment();
      m.n02 = pick_moment();
      m.n30 = pick_moment();
      m.n21 = pick_moment();
      m.n12 = pick_moment();
      m.n03 = pick_moment();
      // Every fifth block of twenty items goes back to back.
      gap = (i % 100 < 20) ? 0 : pick_gap();
      if (i == PAUSE_AT) begin
        // Let the pipeline run dry before going on.
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_hu.size() != 0);
        @(posedge clk);
      end
      offer_moments(m, 1'b0, '0, gap);
    end
    in_valid <= 1'b0;

    // Wait for the last results, then a little longer to catch any extra output.
    do @(negedge clk); while (pending_hu.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hmi_pkg.sv
rtl/core/hmi_mul.sv
rtl/core/hu_moment_invariants.sv
bench/tb_hu_moment_invariants.sv
